### hw/rtl/tpr_pkg.sv
// ----------------------------------------------------------------------------
// tpr_pkg: shared types and constants for the timed pump PWM ramp
// Holds field widths, function and valve codes, and the item and result
// records that pass between the top level and the ramp core.
// ----------------------------------------------------------------------------
package tpr_pkg;

   localparam int SEC_W      = 32;
   localparam int DUR_W      = 32;
   localparam int DUTY_W     = 8;
   localparam int PRESCALE_W = 8;
   localparam int MSCNT_W    = 16;
   localparam int VALVE_W    = 2;
   localparam int NVALVES    = 3;

   localparam int MS_PER_SEC = 1000;
   // Seconds times 1000 needs ten more bits than the seconds value.
   localparam int SEC_MS_W   = SEC_W + 10;
   // Start time in ms plus a 32-bit run length needs one more bit.
   localparam int END_W      = SEC_MS_W + 1;

   localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = PRESCALE_W'(10);

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   localparam logic [VALVE_W-1:0] VALVE_NONE  = 2'd0;
   localparam logic [VALVE_W-1:0] VALVE_ONE   = 2'd1;
   localparam logic [VALVE_W-1:0] VALVE_TWO   = 2'd2;
   localparam logic [VALVE_W-1:0] VALVE_THREE = 2'd3;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic                func;
      logic [SEC_W-1:0]    now_seconds;
      logic [SEC_MS_W-1:0] now_ms_base;
      logic [DUTY_W-1:0]   speed;
      logic [DUR_W-1:0]    duration_ms;
      logic [VALVE_W-1:0]  valve;
   } tpr_item_type;

   typedef struct packed {
      logic              valve_one_n;
      logic              valve_two_n;
      logic              valve_three_n;
      logic [DUTY_W-1:0] duty;
      logic              led_n;
      logic              busy_res;
   } tpr_result_type;

   // Whole seconds to milliseconds; a constant multiply by 1000.
   function automatic logic [SEC_MS_W-1:0] sec_to_ms(input logic [SEC_W-1:0] sec);
      return SEC_MS_W'(sec) * SEC_MS_W'(MS_PER_SEC);
   endfunction

endpackage

### hw/rtl/tpr_core.sv
// ----------------------------------------------------------------------------
// tpr_core: run state and duty ramp of the timed pump PWM
// Holds the run state and produces the result of one beat combinationally from that state and the item.
// ----------------------------------------------------------------------------
module tpr_core
   import tpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  tpr_item_type          item,
   input  logic [PRESCALE_W-1:0] prescale,
   output tpr_result_type        result
);

   logic [SEC_MS_W-1:0]   last_ms_ff,  last_ms_in;
   logic [SEC_W-1:0]      held_sec_ff, held_sec_in;
   logic [MSCNT_W-1:0]    ms_cnt_ff,   ms_cnt_in;
   logic [END_W-1:0]      end_ms_ff,   end_ms_in;
   logic [DUTY_W-1:0]     target_ff,   target_in;
   logic [DUTY_W-1:0]     duty_ff,     duty_in;
   logic [PRESCALE_W-1:0] pre_cnt_ff,  pre_cnt_in;
   logic                  busy_ff,     busy_in;
   logic [NVALVES-1:0]    valve_ff,    valve_in;

   logic [DUR_W-1:0]      run_ms;
   logic [END_W-1:0]      now_ms;

   always_comb begin
      last_ms_in  = last_ms_ff;
      held_sec_in = held_sec_ff;
      ms_cnt_in   = ms_cnt_ff;
      end_ms_in   = end_ms_ff;
      target_in   = target_ff;
      duty_in     = duty_ff;
      pre_cnt_in  = pre_cnt_ff;
      busy_in     = busy_ff;
      valve_in    = valve_ff;
      run_ms      = item.duration_ms + DUR_W'(1);
      now_ms      = END_W'(item.now_ms_base) + END_W'(ms_cnt_ff);

      if (item.func == FUNC_START) begin
         // The start second comes from the last tick, kept here already in ms.
         end_ms_in = END_W'(last_ms_ff) + END_W'(run_ms);
         target_in = item.speed;
         busy_in   = 1'b1;
         case (item.valve)
            VALVE_NONE:  valve_in = 3'b000;
            VALVE_ONE:   valve_in = 3'b001;
            VALVE_TWO:   valve_in = 3'b010;
            VALVE_THREE: valve_in = 3'b100;
            default:     valve_in = 3'b000;
         endcase
      end else begin
         last_ms_in = item.now_ms_base;
         if (busy_ff) begin
            pre_cnt_in = (pre_cnt_ff <= prescale) ? pre_cnt_ff + PRESCALE_W'(1)
                                                  : '0;
            if (end_ms_ff > now_ms) begin
               if ((duty_ff < target_ff) && (pre_cnt_in == '0)) begin
                  duty_in = duty_ff + DUTY_W'(1);
               end else if (duty_ff > target_ff) begin
                  duty_in = duty_ff - DUTY_W'(1);
               end
               if (item.now_seconds != held_sec_ff) begin
                  held_sec_in = item.now_seconds;
                  ms_cnt_in   = MSCNT_W'(1);
               end else begin
                  ms_cnt_in   = ms_cnt_ff + MSCNT_W'(1);
               end
            end else begin
               if ((duty_ff != '0) && (pre_cnt_in == '0)) begin
                  duty_in = duty_ff - DUTY_W'(1);
               end
               if (duty_in == '0) begin
                  target_in = '0;
                  busy_in   = 1'b0;
                  valve_in  = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ms_ff  <= '0;
         held_sec_ff <= '0;
         ms_cnt_ff   <= '0;
         end_ms_ff   <= '0;
         target_ff   <= '0;
         duty_ff     <= '0;
         pre_cnt_ff  <= '0;
         busy_ff     <= 1'b0;
         valve_ff    <= '0;
      end else if (step_en) begin
         last_ms_ff  <= last_ms_in;
         held_sec_ff <= held_sec_in;
         ms_cnt_ff   <= ms_cnt_in;
         end_ms_ff   <= end_ms_in;
         target_ff   <= target_in;
         duty_ff     <= duty_in;
         pre_cnt_ff  <= pre_cnt_in;
         busy_ff     <= busy_in;
         valve_ff    <= valve_in;
      end
   end

   // The result reflects the state after this beat.
   assign result.valve_one_n   = ~valve_in[0];
   assign result.valve_two_n   = ~valve_in[1];
   assign result.valve_three_n = ~valve_in[2];
   assign result.duty          = duty_in;
   assign result.led_n         = (duty_in == '0);
   assign result.busy_res      = busy_in;

`ifndef SYNTH
   a_duty_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (duty_ff != '0) |-> busy_ff)
      else $error("nonzero duty while idle");

   a_valve_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(valve_ff))
      else $error("more than one valve open");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> ((target_ff == '0) && (valve_ff == '0)))
      else $error("idle with run state left over");
`endif

endmodule

### hw/rtl/timed_pump_pwm_ramp_top.sv
// Path: a request beat accepted into the input register passes through the core stage
// and is presented as a response from the response register.
// Throughput: one beat per cycle in each direction while the response side is ready;
// the input register and the response register set this rate.
// Reset: synchronous, active high; clears all run state, sets ramp_prescale to 10.
// ----------------------------------------------------------------------------
// timed_pump_pwm_ramp_top: timed pump PWM with soft start and soft stop
// A start beat latches a target duty, a run length, and a valve choice; tick
// beats carry the current second and step the duty ramp. Each request beat
// produces one response beat with the valve drives, duty, LED and busy flag.
// ----------------------------------------------------------------------------
module timed_pump_pwm_ramp_top
   import tpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata from bit 0: now_seconds[31:0], speed[39:32], duration_ms[71:40],
   // valve[73:72], zero padding[79:74].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: func (0 = tick, 1 = start).
   input  logic                  req_tuser,

   // Response stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata from bit 0: valve_one_n[0], valve_two_n[1], valve_three_n[2],
   // duty[10:3], led_n[11], busy_res[12], zero padding[15:13].
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   // Configuration: ramp_prescale.
   input  logic                  csr_wr_en,
   input  logic [PRESCALE_W-1:0] csr_wr_data
);

   // Prescaler; software must write it only while no beat is in flight, unchecked.
   logic [PRESCALE_W-1:0] prescale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= PRESCALE_RESET;
      end else if (csr_wr_en) begin
         prescale_ff <= csr_wr_data;
      end
   end

   // Input register. The seconds-to-ms multiply is done ahead of it, so the
   // core stage sees only an add and a compare on the time path.
   logic         in_valid_ff;
   tpr_item_type in_item_ff, in_item_in;
   logic         advance;

   // The core stage moves when the response register is empty or draining,
   // so a new beat enters every cycle while the consumer keeps up. A response
   // that is not taken holds the core stage, and with it the input register.
   assign advance    = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_item_in.func        = req_tuser;
      in_item_in.now_seconds = req_tdata[31:0];
      in_item_in.now_ms_base = sec_to_ms(req_tdata[31:0]);
      in_item_in.speed       = req_tdata[39:32];
      in_item_in.duration_ms = req_tdata[71:40];
      in_item_in.valve       = req_tdata[73:72];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= in_item_in;
      end
   end

   // The core updates its run state exactly once per beat, when it advances.
   tpr_result_type core_result;

   tpr_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .item     (in_item_ff),
      .prescale (prescale_ff),
      .result   (core_result)
   );

   // Response register.
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign rsp_data_in = {3'b000,
                         core_result.busy_res,
                         core_result.led_n,
                         core_result.duty,
                         core_result.valve_three_n,
                         core_result.valve_two_n,
                         core_result.valve_one_n};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
